// ----- rtl/kpi_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kpi_pkg: keyframe position interpolator shared definitions
// Sizes, command codes and the key and cell control types.
// ----------------------------------------------------------------------------
package kpi_pkg;

  localparam int MAX_KEYS  = 64;
  localparam int IDX_W     = $clog2(MAX_KEYS);
  localparam int CNT_W     = $clog2(MAX_KEYS + 1);
  localparam int RATE_W    = 10;
  localparam int FRAC_BITS = 16;
  localparam int DIV_STEPS = FRAC_BITS;

  localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(30);

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef struct packed {
    logic signed [31:0] t;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } kpi_key_t;

  typedef struct packed {
    logic shift;
    logic wr;
  } kpi_cell_ctrl_t;

endpackage

// ----- rtl/kpi_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kpi_if: keyframe interpolator channels
// Input item channel and result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface kpi_in_if;
  logic               valid;
  logic               ready;
  logic               cmd;
  logic               restart_table;
  logic signed [31:0] key_time;
  logic signed [31:0] key_x;
  logic signed [31:0] key_y;
  logic signed [31:0] key_z;
  logic signed [31:0] query_time;

  modport source (output valid, cmd, restart_table, key_time, key_x, key_y, key_z,
                  query_time, input ready);
  modport sink (input valid, cmd, restart_table, key_time, key_x, key_y, key_z,
                query_time, output ready);
endinterface

interface kpi_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic               table_empty;

  modport source (output valid, pos_x, pos_y, pos_z, table_empty, input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, table_empty, output ready);
endinterface

// ----- rtl/kpi_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kpi_cell: one keyframe slot of the key ring
// Holds one key; loads a new key or takes its neighbour's key on a shift.
// ----------------------------------------------------------------------------
module kpi_cell
  import kpi_pkg::*;
(
  input  logic           clk,
  input  kpi_cell_ctrl_t ctrl,
  input  kpi_key_t       wr_key,
  input  kpi_key_t       prev_key,
  output kpi_key_t       key
);

  always_ff @(posedge clk) begin
    if (ctrl.wr) begin
      key <= wr_key;
    end else if (ctrl.shift) begin
      key <= prev_key;
    end
  end

endmodule

// ----- rtl/kpi_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kpi_div: fractional ratio divider
// Restoring division of num * 2^16 by den, one quotient bit a cycle; num < den.
// ----------------------------------------------------------------------------
module kpi_div
  import kpi_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [32:0]          num,
  input  logic [32:0]          den,
  output logic                 done,
  output logic [FRAC_BITS-1:0] quot
);

  localparam int STEP_W = $clog2(DIV_STEPS + 1);

  logic [33:0]       rem;
  logic [33:0]       rem_sh;
  logic [32:0]       divisor;
  logic [STEP_W-1:0] steps;
  logic              busy;

  assign rem_sh = {rem[32:0], 1'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy    <= 1'b1;
        steps   <= '0;
        rem     <= {1'b0, num};
        divisor <= den;
        quot    <= '0;
      end else if (busy) begin
        if (rem_sh >= {1'b0, divisor}) begin
          rem  <= rem_sh - {1'b0, divisor};
          quot <= {quot[FRAC_BITS-2:0], 1'b1};
        end else begin
          rem  <= rem_sh;
          quot <= {quot[FRAC_BITS-2:0], 1'b0};
        end
        steps <= steps + 1'b1;
        if (steps == STEP_W'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- rtl/keyframe_position_interpolator_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyframe_position_interpolator_top: keyframe position interpolator
// Key table as a ring of cells, scanned by rotation; linear blend in Q16.16.
// ----------------------------------------------------------------------------
//  channel | direction | contents
//  in_ch   | in        | cmd, restart_table, key_time, key_x/y/z, query_time
//  out_ch  | out       | pos_x, pos_y, pos_z, table_empty (one per query)
//  cfg     | in        | cfg_we, cfg_wdata: frame_rate
//
// A load is taken in ST_IDLE; a query on an empty table goes straight to ST_DONE.
// Other queries run ST_MUL, ST_TRUNC, ST_CLAMP for frame and clamp, one full ring
// turn of MAX_KEYS in ST_SCAN, ST_RESOLVE, ST_PREP, the ratio divider in ST_DIV
// (skipped when no ratio is needed), a multiply/add pair per axis, then ST_DONE.
// One item at a time; a held result stops loads only once a query waits in ST_DONE.
// rst is synchronous; the key cells are not cleared, the key count is.
// ----------------------------------------------------------------------------
module keyframe_position_interpolator_top
  import kpi_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [RATE_W-1:0] cfg_wdata,
  kpi_in_if.sink            in_ch,
  kpi_out_if.source         out_ch
);

  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_MUL     = 4'd1;
  localparam logic [3:0] ST_TRUNC   = 4'd2;
  localparam logic [3:0] ST_CLAMP   = 4'd3;
  localparam logic [3:0] ST_SCAN    = 4'd4;
  localparam logic [3:0] ST_RESOLVE = 4'd5;
  localparam logic [3:0] ST_PREP    = 4'd6;
  localparam logic [3:0] ST_DIV     = 4'd7;
  localparam logic [3:0] ST_BMUL    = 4'd8;
  localparam logic [3:0] ST_BADD    = 4'd9;
  localparam logic [3:0] ST_DONE    = 4'd10;

  localparam logic signed [31:0] RANGE_LOW_RESET  = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] RANGE_HIGH_RESET = 32'sh8000_0000;

  logic [3:0]         state;
  logic [RATE_W-1:0]  frame_rate;
  logic [CNT_W-1:0]   key_count;
  logic signed [31:0] range_low;
  logic signed [31:0] range_high;

  logic signed [31:0] qtime;
  logic signed [42:0] prod;
  logic signed [26:0] frame;
  logic signed [31:0] f;
  logic [IDX_W-1:0]   scan_idx;
  logic               have_start;
  logic               found;
  logic               eq_hit;
  logic               same;
  kpi_key_t           start_key;
  kpi_key_t           end_key;
  kpi_key_t           first_key;
  kpi_key_t           last_key;
  logic [FRAC_BITS-1:0] ratio;
  logic [1:0]         axis;
  logic signed [49:0] blend_p;
  logic signed [31:0] res_x;
  logic signed [31:0] res_y;
  logic signed [31:0] bsat_hold;
  logic               res_empty;
  logic               res_load;

  // key ring
  kpi_key_t       cell_key  [MAX_KEYS];
  kpi_cell_ctrl_t cell_ctrl [MAX_KEYS];
  kpi_key_t       new_key;
  logic           in_acc;
  logic           load_fire;
  logic [CNT_W-1:0] base_cnt;
  logic [IDX_W-1:0] wr_idx;

  assign in_ch.ready = (state == ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign base_cnt    = in_ch.restart_table ? '0 : key_count;
  assign wr_idx      = base_cnt[IDX_W-1:0];
  assign load_fire   = in_acc && (in_ch.cmd == CMD_LOAD) && (base_cnt < CNT_W'(MAX_KEYS));
  assign new_key     = '{t: in_ch.key_time, x: in_ch.key_x, y: in_ch.key_y, z: in_ch.key_z};

  for (genvar g = 0; g < MAX_KEYS; g++) begin : g_cell
    assign cell_ctrl[g].wr    = load_fire && (wr_idx == IDX_W'(g));
    assign cell_ctrl[g].shift = (state == ST_SCAN);
    kpi_cell u_cell (
      .clk      (clk),
      .ctrl     (cell_ctrl[g]),
      .wr_key   (new_key),
      .prev_key (cell_key[(g + 1) % MAX_KEYS]),
      .key      (cell_key[g])
    );
  end

  // frame truncation and clamp
  logic signed [42:0] prod_adj;
  logic signed [32:0] low_sum;
  logic signed [32:0] high_sum;
  logic signed [16:0] low_tr;
  logic signed [16:0] high_tr;
  logic signed [42:0] f_wide;
  logic signed [42:0] low_w;
  logic signed [42:0] high_w;
  logic signed [26:0] frame_a;
  logic signed [42:0] fa_wide;
  logic signed [31:0] f_clamp;

  assign prod_adj = prod + (prod[42] ? 43'sd65535 : 43'sd0);
  assign low_sum  = {range_low[31], range_low} + (range_low[31] ? 33'sd65535 : 33'sd0);
  assign high_sum = {range_high[31], range_high} + (range_high[31] ? 33'sd65535 : 33'sd0);
  assign low_tr   = low_sum[32:16];
  assign high_tr  = high_sum[32:16];
  assign f_wide   = {frame, 16'h0000};
  assign low_w    = {{11{range_low[31]}}, range_low};
  assign high_w   = {{11{range_high[31]}}, range_high};
  assign frame_a  = (f_wide < low_w) ? {{10{low_tr[16]}}, low_tr} : frame;
  assign fa_wide  = {frame_a, 16'h0000};
  assign f_clamp  = (fa_wide > high_w) ? {high_tr[15:0], 16'h0000} : fa_wide[31:0];

  // scan of the ring head
  kpi_key_t head;
  logic     in_table;
  logic     is_last;

  assign head     = cell_key[0];
  assign in_table = CNT_W'(scan_idx) < key_count;
  assign is_last  = CNT_W'(scan_idx) == (key_count - 1'b1);

  // divider
  logic        div_start;
  logic        div_done;
  logic [32:0] div_num;
  logic [32:0] div_den;
  logic [FRAC_BITS-1:0] div_q;

  assign div_start = (state == ST_PREP) && !same;
  assign div_num   = 33'({f[31], f} - {start_key.t[31], start_key.t});
  assign div_den   = 33'({end_key.t[31], end_key.t} - {start_key.t[31], start_key.t});

  kpi_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_q)
  );

  // blend, one axis at a time through a shared multiplier
  logic signed [31:0] va;
  logic signed [31:0] vb;
  logic signed [32:0] vd;
  logic signed [50:0] bsum;
  logic signed [34:0] bres;
  logic signed [31:0] bsat;

  always_comb begin
    case (axis)
      2'd0: begin
        va = start_key.x;
        vb = end_key.x;
      end
      2'd1: begin
        va = start_key.y;
        vb = end_key.y;
      end
      default: begin
        va = start_key.z;
        vb = end_key.z;
      end
    endcase
  end

  assign vd   = {vb[31], vb} - {va[31], va};
  assign bsum = {{3{va[31]}}, va, 16'h0000} + {blend_p[49], blend_p} + 51'sd32768;
  assign bres = bsum[50:16];
  assign bsat = (bres[34:31] == 4'b0000 || bres[34:31] == 4'b1111) ? bres[31:0]
              : (bres[34] ? 32'sh8000_0000 : 32'sh7FFF_FFFF);

  // result register takes a new transaction once the old one is gone or leaving
  assign res_load = (state == ST_DONE) && (!out_ch.valid || out_ch.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      frame_rate    <= RATE_RESET;
      key_count     <= '0;
      range_low     <= RANGE_LOW_RESET;
      range_high    <= RANGE_HIGH_RESET;
      out_ch.valid  <= 1'b0;
      scan_idx      <= '0;
      axis          <= '0;
    end else begin
      if (cfg_we) begin
        frame_rate <= cfg_wdata;
      end
      if (res_load) begin
        out_ch.valid <= 1'b1;
      end else if (out_ch.valid && out_ch.ready) begin
        out_ch.valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (in_acc) begin
            if (in_ch.cmd == CMD_LOAD) begin
              // a restart always leaves room, so it always appends
              if (load_fire) begin
                key_count <= base_cnt + 1'b1;
                if (in_ch.restart_table || in_ch.key_time < range_low) begin
                  range_low <= in_ch.key_time;
                end
                if (in_ch.restart_table || in_ch.key_time > range_high) begin
                  range_high <= in_ch.key_time;
                end
              end
            end else if (key_count == '0) begin
              res_x     <= '0;
              res_y     <= '0;
              bsat_hold <= '0;
              res_empty <= 1'b1;
              state     <= ST_DONE;
            end else begin
              qtime <= in_ch.query_time;
              state <= ST_MUL;
            end
          end
        end
        ST_MUL: begin
          prod  <= qtime * $signed({1'b0, frame_rate});
          state <= ST_TRUNC;
        end
        ST_TRUNC: begin
          frame <= prod_adj[42:16];
          state <= ST_CLAMP;
        end
        ST_CLAMP: begin
          f          <= f_clamp;
          scan_idx   <= '0;
          have_start <= 1'b0;
          found      <= 1'b0;
          eq_hit     <= 1'b0;
          state      <= ST_SCAN;
        end
        ST_SCAN: begin
          if (in_table) begin
            if (scan_idx == '0) begin
              first_key <= head;
            end
            if (is_last) begin
              last_key <= head;
            end
            if (!found) begin
              if (f == head.t) begin
                start_key  <= head;
                end_key    <= head;
                have_start <= 1'b1;
                found      <= 1'b1;
                eq_hit     <= 1'b1;
              end else if (f > head.t) begin
                start_key  <= head;
                have_start <= 1'b1;
              end else begin
                end_key <= head;
                found   <= 1'b1;
              end
            end
          end
          scan_idx <= scan_idx + 1'b1;
          if (scan_idx == IDX_W'(MAX_KEYS - 1)) begin
            state <= ST_RESOLVE;
          end
        end
        ST_RESOLVE: begin
          if (!have_start) begin
            start_key <= found ? first_key : last_key;
          end
          if (!found) begin
            end_key <= last_key;
          end
          same  <= !(have_start && found && !eq_hit);
          state <= ST_PREP;
        end
        ST_PREP: begin
          axis <= '0;
          if (same) begin
            ratio <= '0;
            state <= ST_BMUL;
          end else begin
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            ratio <= div_q;
            state <= ST_BMUL;
          end
        end
        ST_BMUL: begin
          blend_p <= vd * $signed({1'b0, ratio});
          state   <= ST_BADD;
        end
        ST_BADD: begin
          case (axis)
            2'd0:    res_x     <= bsat;
            2'd1:    res_y     <= bsat;
            default: bsat_hold <= bsat;
          endcase
          if (axis == 2'd2) begin
            res_empty <= 1'b0;
            state     <= ST_DONE;
          end else begin
            axis  <= axis + 1'b1;
            state <= ST_BMUL;
          end
        end
        ST_DONE: begin
          if (res_load) begin
            out_ch.pos_x       <= res_x;
            out_ch.pos_y       <= res_y;
            out_ch.pos_z       <= bsat_hold;
            out_ch.table_empty <= res_empty;
            state              <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- bench/kpi_scoreboard.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kpi_scoreboard: keyframe interpolator result checker
// Watches the item, result and frame rate ports, keeps its own key table and
// works out the blended position of every query, then compares each result
// transaction in order with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module kpi_scoreboard
  import kpi_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [RATE_W-1:0] cfg_wdata,
  kpi_in_if                 in_ch,
  kpi_out_if                out_ch,
  output int                pending,
  output int                errors,
  output int                queries_seen
);

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic               empty;
  } position_t;

  logic signed [31:0] tab_t[MAX_KEYS];
  logic signed [31:0] tab_x[MAX_KEYS];
  logic signed [31:0] tab_y[MAX_KEYS];
  logic signed [31:0] tab_z[MAX_KEYS];
  int                 n_keys;
  logic signed [31:0] span_lo;
  logic signed [31:0] span_hi;
  logic [RATE_W-1:0]  rate;
  position_t          positions_due[$];

  function automatic longint floor16(input longint s);
    if (s >= 0) return s / 65536;
    return -((-s + 65535) / 65536);
  endfunction

  function automatic logic signed [31:0] mix(input logic signed [31:0] a,
                                              input logic signed [31:0] b,
                                              input longint r);
    longint s;
    s = floor16(longint'(a) * (65536 - r) + longint'(b) * r + 32768);
    if (s > 64'sd2147483647) s = 64'sd2147483647;
    if (s < -64'sd2147483648) s = -64'sd2147483648;
    return s[31:0];
  endfunction

  function automatic position_t interpolate(input logic signed [31:0] q);
    position_t res;
    longint    frame, f, num, den, p, ap, ad, r;
    int        si, ei;
    bit        have_start, found;
    res = '{0, 0, 0, 1'b1};
    if (n_keys == 0) return res;
    frame = (longint'(q) * longint'(rate)) / 65536;
    if (frame * 65536 < longint'(span_lo)) frame = longint'(span_lo) / 65536;
    if (frame * 65536 > longint'(span_hi)) frame = longint'(span_hi) / 65536;
    f = frame * 65536;
    si = 0; ei = 0; have_start = 0; found = 0;
    for (int i = 0; i < n_keys; i++) begin
      if (f == longint'(tab_t[i])) begin
        si = i; ei = i; have_start = 1; found = 1;
        break;
      end else if (f > longint'(tab_t[i])) begin
        si = i; have_start = 1;
      end else begin
        ei = i; found = 1;
        break;
      end
    end
    if (!have_start) si = 0;
    if (!found) begin
      ei = n_keys - 1;
      if (!have_start) si = n_keys - 1;
    end
    r = 0;
    if (si != ei) begin
      den = longint'(tab_t[ei]) - longint'(tab_t[si]);
      num = f - longint'(tab_t[si]);
      if (den != 0) begin
        p  = num * 65536;
        ap = (p < 0) ? -p : p;
        ad = (den < 0) ? -den : den;
        if ((p >= 0) == (den > 0)) r = ap / ad;
        else r = -((ap + ad - 1) / ad);
      end
    end
    res.x = mix(tab_x[si], tab_x[ei], r);
    res.y = mix(tab_y[si], tab_y[ei], r);
    res.z = mix(tab_z[si], tab_z[ei], r);
    res.empty = 1'b0;
    return res;
  endfunction

  always @(posedge clk) begin
    position_t want;
    if (rst) begin
      n_keys  = 0;
      span_lo = 32'sh7FFF_FFFF;
      span_hi = 32'sh8000_0000;
      rate    = RATE_RESET;
      errors  = 0;
      queries_seen = 0;
      positions_due.delete();
    end else begin
      // results first: a result never belongs to an item taken at the same edge
      if (out_ch.valid && out_ch.ready) begin
        if (positions_due.size() == 0) begin
          if (errors < 10) $display("%0t: result with nothing outstanding", $realtime);
          errors = errors + 1;
        end else begin
          want = positions_due.pop_front();
          if (out_ch.pos_x !== want.x || out_ch.pos_y !== want.y ||
              out_ch.pos_z !== want.z || out_ch.table_empty !== want.empty) begin
            if (errors < 10)
              $display("%0t: expected x=%h y=%h z=%h e=%b got x=%h y=%h z=%h e=%b",
                       $realtime, want.x, want.y, want.z, want.empty, out_ch.pos_x,
                       out_ch.pos_y, out_ch.pos_z, out_ch.table_empty);
            errors = errors + 1;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        if (in_ch.cmd == CMD_QUERY) begin
          positions_due.push_back(interpolate(in_ch.query_time));
          queries_seen = queries_seen + 1;
        end else begin
          if (in_ch.restart_table) begin
            n_keys  = 0;
            span_lo = 32'sh7FFF_FFFF;
            span_hi = 32'sh8000_0000;
          end
          if (n_keys < MAX_KEYS) begin
            tab_t[n_keys] = in_ch.key_time;
            tab_x[n_keys] = in_ch.key_x;
            tab_y[n_keys] = in_ch.key_y;
            tab_z[n_keys] = in_ch.key_z;
            n_keys = n_keys + 1;
            if (in_ch.key_time < span_lo) span_lo = in_ch.key_time;
            if (in_ch.key_time > span_hi) span_hi = in_ch.key_time;
          end
        end
      end
      if (cfg_we) rate = cfg_wdata;
    end
    pending = positions_due.size();
  end

endmodule

// ----- bench/keyframe_position_interpolator_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyframe_position_interpolator_top_tb: interpolator stimulus and verdict
// Loads key tables and sends queries under several frame rates, with random
// gaps on both channels and one long output stall; the scoreboard checks.
// ----------------------------------------------------------------------------
module keyframe_position_interpolator_top_tb;
  import kpi_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE      = 120;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_we = 1'b0;
  logic [RATE_W-1:0] cfg_wdata = '0;
  logic              steady = 1'b0;
  logic              hold_out = 1'b0;
  int                pending, errors, queries_seen;
  int                sent = 0, cycles = 0, rates_used = 0;
  logic [RATE_W-1:0] cur_rate = RATE_RESET;
  longint            lo_frame, hi_frame;

  kpi_in_if  in_ch();
  kpi_out_if out_ch();

  keyframe_position_interpolator_top dut (
    .clk, .rst, .cfg_we, .cfg_wdata, .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  kpi_scoreboard checker_i (
    .clk, .rst, .cfg_we, .cfg_wdata, .in_ch, .out_ch, .pending, .errors, .queries_seen
  );

  always #5 clk = ~clk;

  initial begin
    in_ch.valid = 1'b0; in_ch.cmd = CMD_LOAD; in_ch.restart_table = 1'b0;
    in_ch.key_time = '0; in_ch.key_x = '0; in_ch.key_y = '0; in_ch.key_z = '0;
    in_ch.query_time = '0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles", cycles);
      $display("Mismatches found");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst || hold_out) out_ch.ready <= 1'b0;
    else if (steady) out_ch.ready <= 1'b1;
    else out_ch.ready <= ($urandom_range(99) >= 17);
  end

  // long receiver hold-off while loads and queries keep coming
  initial begin
    int held;
    wait (sent >= 600);
    @(posedge clk);
    hold_out <= 1'b1;
    held = 0;
    while (held < 600) begin
      @(posedge clk);
      held++;
    end
    hold_out <= 1'b0;
  end

  task automatic send(input logic c, input logic rs, input logic signed [31:0] t,
                      input logic signed [31:0] x, input logic signed [31:0] y,
                      input logic signed [31:0] z, input logic signed [31:0] q);
    while (!steady && $urandom_range(99) < 17) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1; in_ch.cmd <= c; in_ch.restart_table <= rs;
    in_ch.key_time <= t; in_ch.key_x <= x; in_ch.key_y <= y; in_ch.key_z <= z;
    in_ch.query_time <= q;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sent++;
  endtask

  task automatic load(input logic rs, input logic signed [31:0] t);
    send(CMD_LOAD, rs, t, $urandom, $urandom, $urandom, $urandom);
  endtask

  task automatic query(input logic signed [31:0] q);
    send(CMD_QUERY, 1'($urandom_range(1)), $urandom, $urandom, $urandom, $urandom, q);
  endtask

  task automatic set_rate(input logic [RATE_W-1:0] r);
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_we <= 1'b1; cfg_wdata <= r;
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_rate = r;
    rates_used++;
  endtask

  // non-descending table starting near base, n keys, steps of up to max_step frames
  task automatic build_table(input int n, input longint base, input int max_step);
    longint t;
    t = base * 65536 + ($urandom_range(3) == 0 ? $urandom_range(65535) : 0);
    lo_frame = t / 65536;
    for (int i = 0; i < n; i++) begin
      if (t > 64'sd2147483647) t = 64'sd2147483647;
      load(i == 0, t[31:0]);
      hi_frame = t / 65536;
      t += longint'($urandom_range(max_step)) * 65536
           + ($urandom_range(4) == 0 ? $urandom_range(65535) : 0);
    end
  endtask

  task automatic aimed_query();
    longint target, q;
    target = lo_frame - 3 + longint'($urandom_range(int'(hi_frame - lo_frame) + 6));
    if (cur_rate == 0) q = $urandom;
    else q = (target * 65536) / longint'(cur_rate) + longint'($urandom_range(64)) - 32;
    if (q > 64'sd2147483647) q = 64'sd2147483647;
    if (q < -64'sd2147483648) q = -64'sd2147483648;
    query(q[31:0]);
  endtask

  initial begin
    logic [RATE_W-1:0] rate_plan[7];
    int                n, goal;
    rate_plan = '{10'd30, 10'd1, 10'd1000, 10'd0, 10'd1023, 10'd24,
                  10'(1 + $urandom_range(999))};
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty table, extreme keys, exact hits, before and past, restart
    query(32'sh0000_0000);
    load(1'b0, 32'sh8000_0000);
    send(CMD_LOAD, 1'b0, 32'sh0000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000,
         32'sh0000_0001, 32'sh0);
    send(CMD_LOAD, 1'b0, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF,
         32'shFFFF_FFFF, 32'sh0);
    query(32'sh8000_0000);
    query(32'sh7FFF_FFFF);
    query(32'sh0000_0000);
    query(32'sh0000_8000);
    query(32'shFFFF_0000);
    send(CMD_LOAD, 1'b1, 32'sh000A_0000, 32'sh0001_0000, 32'sh0002_0000,
         32'sh0003_0000, 32'sh0);
    send(CMD_LOAD, 1'b0, 32'sh0014_8000, 32'shFFFF_0000, 32'sh7FFF_0000,
         32'sh8000_0000, 32'sh0);
    query(32'sh0000_0000);
    query(32'sh0000_5555);
    query(32'sh0000_8000);
    query(32'sh0000_A000);
    query(32'sh7FFF_FFFF);
    load(1'b1, 32'sh0001_0000);
    query($urandom);
    query(32'sh8000_0000);

    // random phases, one frame rate each; the third one runs without gaps
    for (int ph = 0; ph < 7; ph++) begin
      set_rate(rate_plan[ph]);
      steady = (ph == 2);
      goal = sent + 185;
      while (sent < goal) begin
        case ($urandom_range(9))
          0: n = 64 + $urandom_range(3);
          1: n = 1;
          default: n = 2 + $urandom_range(10);
        endcase
        if ($urandom_range(9) == 0)
          build_table(n, longint'($signed($urandom)) / 131072, 30000);
        else
          build_table(n, longint'($urandom_range(600)) - 300, 40);
        repeat (2 + $urandom_range(10)) begin
          if ($urandom_range(9) == 0) query($urandom);
          else if ($urandom_range(19) == 0) load(1'b0, $urandom);
          else aimed_query();
        end
      end
      steady = 1'b0;
    end

    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    $display("Sent %0d items, %0d of them queries, across %0d frame rates",
             sent, queries_seen, rates_used);
    $display("Tables of 1 to over 64 keys, exact and bracketing hits, clamping");
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("%0d mismatching results", errors);
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/kpi_pkg.sv
rtl/kpi_if.sv
rtl/kpi_cell.sv
rtl/kpi_div.sv
rtl/keyframe_position_interpolator_top.sv
bench/kpi_scoreboard.sv
bench/keyframe_position_interpolator_top_tb.sv
